/* src/ewc_pkg.sv */
// Shared package for the whitespace compressor: widths, character codes,
// register indexes, the job and control structs and the tab size helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ewc_pkg;

	localparam int COL_W      = 7;
	localparam int TS_W       = 5;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	// Column limit; columns saturate here
	localparam logic [COL_W-1:0] MAX_COLUMN = 7'd120;

	localparam logic [TS_W-1:0] TAB_MIN     = 5'd2;
	localparam logic [TS_W-1:0] TAB_DEFAULT = 5'd4;

	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TAB_SIZE      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEEP_TRAILING = 1'b1;

	localparam int QUEUE_DEPTH_DEF = 2;

	// One emit job: whitespace from from_col up to to_col, then data
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic [COL_W-1:0]  from_col;
		logic [TS_W-1:0]   from_phase;
		logic [COL_W-1:0]  to_col;
	} ewc_job_t;

	typedef struct packed {
		logic             start;
		logic [COL_W-1:0] dividend;
	} ewc_div_req_t;

	typedef struct packed {
		logic            done;
		logic [TS_W-1:0] rem;
	} ewc_div_rsp_t;

	typedef struct packed {
		logic resync;
		logic dirty;
	} ewc_front_stat_t;

	// Tab sizes below the minimum fall back to the default
	function automatic logic [TS_W-1:0] eff_tab(input logic [TS_W-1:0] ts);
		return (ts < TAB_MIN) ? TAB_DEFAULT : ts;
	endfunction

endpackage

`default_nettype wire

/* src/entab_whitespace_compressor.sv */
// Whitespace compressor top level: turns runs of spaces and tabs into tabs and spaces.
// An accepted item goes through the job queue; the back end, when idle, then
// registers its first output byte.
// One byte per cycle in while in_stall is low; an item holds the back end for
// each gap byte and then its byte, and input stalls when the job queue fills.
// A tab_size write, or a tab that runs into the column limit, stalls input for
// the phase recompute in the front end. Async reset: columns zero, defaults.
`timescale 1ns / 1ps
`default_nettype none

module entab_whitespace_compressor #(
	parameter int QUEUE_DEPTH = ewc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [ewc_pkg::BYTE_W-1:0]     data_byte,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [ewc_pkg::BYTE_W-1:0]          out_byte,
	output logic                                run_last,
	input  wire logic                           cfg_wr_en,
	input  wire logic [ewc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ewc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ewc_pkg::*;

	logic [TS_W-1:0] tab_size_q;
	logic            keep_trailing_q;
	logic [TS_W-1:0] tab_eff;
	logic            tab_wr;

	logic            q_push, q_pop, q_empty, q_full;
	ewc_job_t        q_wdata, q_rdata;
	ewc_front_stat_t front_stat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_size_q      <= TAB_DEFAULT;
			keep_trailing_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_TAB_SIZE:      tab_size_q      <= cfg_data[TS_W-1:0];
				CFG_KEEP_TRAILING: keep_trailing_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign tab_eff = eff_tab(tab_size_q);
	assign tab_wr  = cfg_wr_en && (cfg_index == CFG_TAB_SIZE);

	ewc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.tab_eff       (tab_eff),
		.keep_trailing (keep_trailing_q),
		.tab_wr        (tab_wr),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.q_full        (q_full),
		.push          (q_push),
		.job           (q_wdata),
		.stat          (front_stat)
	);

	ewc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.full   (q_full)
	);

	ewc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tab_eff    (tab_eff),
		.head       (q_rdata),
		.head_empty (q_empty),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_last   (run_last)
	);

	// Queue never written when full nor read when empty
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("job queue underflow");

	// No byte may enter while column phases are being recomputed
	a_resync_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(front_stat.resync || front_stat.dirty) |-> in_stall)
		else $error("input accepted during phase resync");

endmodule

`default_nettype wire

/* src/ewc_remainder.sv */
// Iterative remainder unit: column modulo tab size, one quotient bit per cycle.
// Depends on ewc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ewc_remainder (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [ewc_pkg::TS_W-1:0]   divisor,
	input  wire ewc_pkg::ewc_div_req_t      req,
	output ewc_pkg::ewc_div_rsp_t           rsp
);
	import ewc_pkg::*;

	localparam int STEPS = COL_W;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [TS_W-1:0]  rem_q;
	logic [COL_W-1:0] quo_q;

	logic [TS_W:0]    shifted;
	logic [TS_W:0]    diff;
	logic [TS_W-1:0]  rem_next;

	// Restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		shifted  = {rem_q, quo_q[COL_W-1]};
		diff     = shifted - {1'b0, divisor};
		rem_next = (shifted >= {1'b0, divisor}) ? diff[TS_W-1:0] : shifted[TS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(STEPS);
			rem_q  <= '0;
			quo_q  <= req.dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[COL_W-2:0], 1'b0};
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

/* src/ewc_front.sv */
// Front end: accepts text bytes, tracks the column state and queues emit jobs
// for printing bytes and newlines. Depends on ewc_pkg and ewc_remainder.
`timescale 1ns / 1ps
`default_nettype none

module ewc_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [ewc_pkg::TS_W-1:0]     tab_eff,
	input  wire logic                         keep_trailing,
	input  wire logic                         tab_wr,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [ewc_pkg::BYTE_W-1:0]   data_byte,
	input  wire logic                         q_full,
	output logic                              push,
	output ewc_pkg::ewc_job_t                 job,
	output ewc_pkg::ewc_front_stat_t          stat
);
	import ewc_pkg::*;

	localparam logic [1:0] F_RUN     = 2'd0;
	localparam logic [1:0] F_DIV_COL = 2'd1;
	localparam logic [1:0] F_DIV_GAP = 2'd2;

	logic [1:0]       state_q;
	logic             dirty_q;
	logic [COL_W-1:0] col_q;
	logic [TS_W-1:0]  phase_q;
	logic [COL_W-1:0] gap_q;
	logic [TS_W-1:0]  gap_phase_q;

	ewc_div_req_t div_req;
	ewc_div_rsp_t div_rsp;

	logic             accept;
	logic             is_tab, is_space, is_nl, is_print;
	logic             col_at_max, has_gap, emit_gap;
	logic [COL_W-1:0] col_inc;
	logic [TS_W-1:0]  phase_inc;
	logic [TS_W-1:0]  tab_step;
	logic [COL_W:0]   tab_next;
	logic             tab_over;

	ewc_remainder u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.divisor (tab_eff),
		.req     (div_req),
		.rsp     (div_rsp)
	);

	// Classify the byte and work out the next column
	always_comb begin
		in_stall = dirty_q || (state_q != F_RUN) || q_full;
		accept   = in_valid && !in_stall;
		is_tab   = (data_byte == CH_TAB);
		is_space = (data_byte == CH_SPACE);
		is_nl    = (data_byte == CH_NL);
		is_print = !is_tab && !is_space && !is_nl;

		col_at_max = (col_q >= MAX_COLUMN);
		col_inc    = col_at_max ? col_q : col_q + COL_W'(1);
		if (col_at_max)
			phase_inc = phase_q;
		else if (phase_q + TS_W'(1) == tab_eff)
			phase_inc = '0;
		else
			phase_inc = phase_q + TS_W'(1);

		tab_step = tab_eff - phase_q;
		tab_next = (COL_W+1)'(col_q) + (COL_W+1)'(tab_step);
		tab_over = tab_next > (COL_W+1)'(MAX_COLUMN);

		has_gap  = col_q > gap_q;
		emit_gap = is_nl ? (keep_trailing && has_gap) : has_gap;
	end

	// Job handed to the back end
	always_comb begin
		push           = accept && (is_nl || is_print);
		job.data       = data_byte;
		job.from_col   = emit_gap ? gap_q : col_q;
		job.from_phase = gap_phase_q;
		job.to_col     = col_q;
	end

	// Phase resync requests: column first, then gap start
	always_comb begin
		div_req.start    = (state_q == F_RUN && dirty_q) ||
		                   (state_q == F_DIV_COL && div_rsp.done);
		div_req.dividend = (state_q == F_RUN) ? col_q : gap_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_RUN;
			dirty_q     <= 1'b0;
			col_q       <= '0;
			phase_q     <= '0;
			gap_q       <= '0;
			gap_phase_q <= '0;
		end else if (tab_wr) begin
			// New tab size: stored phases are stale
			dirty_q <= 1'b1;
			state_q <= F_RUN;
		end else begin
			case (state_q)
				F_RUN: begin
					if (dirty_q) begin
						state_q <= F_DIV_COL;
					end else if (accept) begin
						if (is_tab) begin
							if (tab_over) begin
								col_q <= MAX_COLUMN;
								if (!col_at_max)
									dirty_q <= 1'b1;
							end else begin
								col_q   <= tab_next[COL_W-1:0];
								phase_q <= '0;
							end
						end else if (is_space) begin
							col_q   <= col_inc;
							phase_q <= phase_inc;
						end else if (is_nl) begin
							col_q       <= '0;
							phase_q     <= '0;
							gap_q       <= '0;
							gap_phase_q <= '0;
						end else begin
							col_q       <= col_inc;
							phase_q     <= phase_inc;
							gap_q       <= col_inc;
							gap_phase_q <= phase_inc;
						end
					end
				end
				F_DIV_COL: begin
					if (div_rsp.done) begin
						phase_q <= div_rsp.rem;
						state_q <= F_DIV_GAP;
					end
				end
				F_DIV_GAP: begin
					if (div_rsp.done) begin
						gap_phase_q <= div_rsp.rem;
						dirty_q     <= 1'b0;
						state_q     <= F_RUN;
					end
				end
				default: begin
					state_q <= F_RUN;
				end
			endcase
		end
	end

	assign stat.resync = (state_q != F_RUN);
	assign stat.dirty  = dirty_q;

endmodule

`default_nettype wire

/* src/ewc_queue.sv */
// Short job queue between the front and back ends.
// Depends on ewc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ewc_queue #(
	parameter int DEPTH = ewc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire ewc_pkg::ewc_job_t  wdata,
	input  wire logic               pop,
	output ewc_pkg::ewc_job_t       rdata,
	output logic                    empty,
	output logic                    full
);
	import ewc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ewc_job_t         slot_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign rdata = slot_q[rptr_q];

	// Payload slots need no reset
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= ptr_inc(wptr_q);
			if (pop)
				rptr_q <= ptr_inc(rptr_q);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

/* src/ewc_back.sv */
// Back end: walks one job at a time, emitting tabs and spaces for the gap and
// then the job's byte, one output byte per cycle unless stalled. Depends on ewc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ewc_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [ewc_pkg::TS_W-1:0]   tab_eff,
	input  wire ewc_pkg::ewc_job_t          head,
	input  wire logic                       head_empty,
	output logic                            pop,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [ewc_pkg::BYTE_W-1:0]      out_byte,
	output logic                            run_last
);
	import ewc_pkg::*;

	logic                active_q;
	ewc_job_t            cur_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                run_last_q;

	ewc_job_t            cur;
	ewc_job_t            cur_next;
	logic                cur_valid, slot_free, fire, at_end, stop_fits;
	logic [TS_W-1:0]     step;
	logic [COL_W:0]      stop_col;
	logic [BYTE_W-1:0]   emit_byte;

	// Current job: the one in progress, else the queue head
	always_comb begin
		cur       = active_q ? cur_q : head;
		cur_valid = active_q || !head_empty;
		slot_free = !out_valid_q || !out_stall;
		fire      = slot_free && cur_valid;
		pop       = fire && !active_q;

		at_end    = (cur.from_col == cur.to_col);
		step      = tab_eff - cur.from_phase;
		stop_col  = (COL_W+1)'(cur.from_col) + (COL_W+1)'(step);
		stop_fits = stop_col <= (COL_W+1)'(cur.to_col);

		// A tab if the next stop is reached, a space if it is one column off
		if (at_end)
			emit_byte = cur.data;
		else if (stop_fits && step != TS_W'(1))
			emit_byte = CH_TAB;
		else
			emit_byte = CH_SPACE;

		cur_next = cur;
		if (stop_fits) begin
			cur_next.from_col   = stop_col[COL_W-1:0];
			cur_next.from_phase = '0;
		end else begin
			cur_next.from_col   = cur.from_col + COL_W'(1);
			cur_next.from_phase = cur.from_phase + TS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (fire && !at_end)
			cur_q <= cur_next;
		if (fire) begin
			out_byte_q <= emit_byte;
			run_last_q <= at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				active_q    <= !at_end;
				out_valid_q <= 1'b1;
			end else if (slot_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;

endmodule

`default_nettype wire

/* test/tb_entab_whitespace_compressor.sv */
`timescale 1ns / 1ps
// Self-checking testbench for entab_whitespace_compressor: directed rows, then
// phases of random text under several tab sizes, checked against a column model.
// Depends on ewc_pkg and the RTL of the block only.

module tb_entab_whitespace_compressor;
	import ewc_pkg::*;

	localparam int SETTLE_CYCLES = 40;   // covers the tab-size recompute after the last byte
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_ITEMS   = 50;
	localparam int NUM_PHASES    = 8;

	typedef struct packed {
		logic [BYTE_W-1:0] b;
		logic              run_end;
	} out_item_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// n_typed < 0: expectation comes from the column model
	typedef struct {
		row_kind_t             kind;
		logic [BYTE_W-1:0]     val;
		logic [CFG_IDX_W-1:0]  idx;
		int                    n_typed;
		logic [BYTE_W-1:0]     t0, t1, t2;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic [BYTE_W-1:0]     data_byte;
	logic                  out_stall;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	wire                   in_stall;
	wire                   out_valid;
	wire  [BYTE_W-1:0]     out_byte;
	wire                   run_last;

	entab_whitespace_compressor u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Column model state and configuration
	logic [COL_W-1:0] col_pos;
	logic [COL_W-1:0] gap_col;
	logic [TS_W-1:0]  tab_cfg;
	logic             keep_cfg;

	out_item_t expected_bytes[$];
	out_item_t step_bytes[$];
	dir_row_t  directed_rows[$];
	out_item_t want;

	int  errors;
	int  items_in;
	int  bytes_out;
	int  cfg_writes;
	int  limit_hits;
	bit  no_gaps;
	bit  hold_req;

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit
	initial begin
		#10_000_000;
		$display("  timeout at %0t, %0d bytes still expected", $time, expected_bytes.size());
		$display("entab_whitespace_compressor test failed");
		$finish;
	end

	// Random idle length: mostly none, some short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	// Receiver stall, with one long hold-off on request
	initial begin
		int n;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else begin
				n = idle_len();
				if (n == 0) begin
					out_stall <= 1'b0;
				end else begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// Output checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				errors++;
				$display("%0t: output expected nothing actual byte %02h run_last %b",
					$time, out_byte, run_last);
			end else begin
				want = expected_bytes.pop_front();
				bytes_out++;
				if (out_byte !== want.b) begin
					errors++;
					$display("%0t: out_byte expected %02h actual %02h",
						$time, want.b, out_byte);
				end
				if (run_last !== want.run_end) begin
					errors++;
					$display("%0t: run_last expected %b actual %b (byte %02h)",
						$time, want.run_end, run_last, out_byte);
				end
			end
		end
	end

	// Tab stop pitch; too-small settings fall back to the default
	function automatic int stop_pitch();
		return (tab_cfg < 2) ? 4 : int'(tab_cfg);
	endfunction

	// Whitespace from from_c to to_c: tabs (or a space one column short), then spaces
	task automatic push_gap(input int from_c, input int to_c);
		int ts;
		int last_stop;
		int step;
		ts = stop_pitch();
		last_stop = to_c - (to_c % ts);
		while (from_c < last_stop) begin
			step = ts - (from_c % ts);
			step_bytes.push_back('{b: (step == 1) ? CH_SPACE : CH_TAB, run_end: 1'b0});
			from_c += step;
		end
		while (from_c < to_c) begin
			step_bytes.push_back('{b: CH_SPACE, run_end: 1'b0});
			from_c++;
		end
	endtask

	// Column model: one input byte into step_bytes, state updated
	task automatic entab_predict(input logic [BYTE_W-1:0] c);
		int ts;
		int t;
		step_bytes.delete();
		ts = stop_pitch();
		if (c == CH_TAB) begin
			t = int'(col_pos) + ts;
			t -= t % ts;
			if (t >= int'(MAX_COLUMN)) begin
				col_pos = MAX_COLUMN;
				limit_hits++;
			end else begin
				col_pos = t[COL_W-1:0];
			end
		end else if (c == CH_SPACE) begin
			if (col_pos < MAX_COLUMN)
				col_pos++;
		end else if (c == CH_NL) begin
			if (keep_cfg && col_pos > gap_col)
				push_gap(gap_col, col_pos);
			step_bytes.push_back('{b: CH_NL, run_end: 1'b0});
			col_pos = '0;
			gap_col = '0;
		end else begin
			if (col_pos > gap_col)
				push_gap(gap_col, col_pos);
			step_bytes.push_back('{b: c, run_end: 1'b0});
			if (col_pos < MAX_COLUMN)
				col_pos++;
			else
				limit_hits++;
			gap_col = col_pos;
		end
		if (step_bytes.size() > 0)
			step_bytes[step_bytes.size()-1].run_end = 1'b1;
	endtask

	// Offer one item after a random gap; expectations are queued at acceptance
	task automatic send_item(input logic [BYTE_W-1:0] c, input int n_typed,
			input logic [BYTE_W-1:0] t0, input logic [BYTE_W-1:0] t1,
			input logic [BYTE_W-1:0] t2);
		int g;
		logic [BYTE_W-1:0] typed [3];
		g = idle_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= c;
		do @(posedge clk); while (in_stall);
		items_in++;
		entab_predict(c);
		if (n_typed < 0) begin
			foreach (step_bytes[k])
				expected_bytes.push_back(step_bytes[k]);
		end else begin
			typed[0] = t0;
			typed[1] = t1;
			typed[2] = t2;
			for (int k = 0; k < n_typed; k++)
				expected_bytes.push_back('{b: typed[k], run_end: (k == n_typed - 1)});
		end
	endtask

	// Stop offering, wait for every expected byte, then let trailing work finish
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		if (idx == CFG_TAB_SIZE)
			tab_cfg = val[TS_W-1:0];
		else
			keep_cfg = val[0];
		cfg_writes++;
	endtask

	function automatic void add_item(input logic [BYTE_W-1:0] c, input int n,
			input logic [BYTE_W-1:0] t0 = '0, input logic [BYTE_W-1:0] t1 = '0,
			input logic [BYTE_W-1:0] t2 = '0);
		dir_row_t row;
		row.kind    = ROW_ITEM;
		row.val     = c;
		row.idx     = '0;
		row.n_typed = n;
		row.t0      = t0;
		row.t1      = t1;
		row.t2      = t2;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [BYTE_W-1:0] val);
		dir_row_t row;
		row.kind    = ROW_CFG;
		row.val     = val;
		row.idx     = idx;
		row.n_typed = -1;
		row.t0      = '0;
		row.t1      = '0;
		row.t2      = '0;
		directed_rows.push_back(row);
	endfunction

	// Random text: words, whitespace runs, line breaks, a little raw noise
	function automatic logic [BYTE_W-1:0] text_byte(input int nl_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < nl_pct)
			return CH_NL;
		if (r < nl_pct + 25)
			return CH_SPACE;
		if (r < nl_pct + 37)
			return CH_TAB;
		if (r >= 95)
			return BYTE_W'($urandom_range(0, 255));
		return BYTE_W'($urandom_range(8'h21, 8'h7E));
	endfunction

	// Main sequence
	initial begin
		int ph_tab  [NUM_PHASES];
		int ph_keep [NUM_PHASES];
		int ph_nl   [NUM_PHASES];
		int ts_val;
		int keep_val;

		ph_tab  = '{2, 3, 8, 16, 17, 31, 1, -1};
		ph_keep = '{0, 1, 0, 1, 1, 0, 1, -1};
		ph_nl   = '{8, 6, 2, 10, 4, 1, 8, 5};

		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		data_byte <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		errors     = 0;
		items_in   = 0;
		bytes_out  = 0;
		cfg_writes = 0;
		limit_hits = 0;
		no_gaps    = 1'b0;
		hold_req   = 1'b0;
		col_pos    = '0;
		gap_col    = '0;
		tab_cfg    = TAB_DEFAULT;
		keep_cfg   = 1'b0;

		// Reset defaults: tab stops every 4, trailing whitespace trimmed
		add_item(8'h41, 1, 8'h41);
		add_item(8'h00, 1, 8'h00);
		add_item(8'hFF, 1, 8'hFF);
		add_item(CH_SPACE, 0);
		add_item(8'h42, 2, CH_SPACE, 8'h42);     // stop one column away
		add_item(CH_TAB, 0);
		add_item(8'h43, 2, CH_TAB, 8'h43);
		add_item(CH_SPACE, 0);
		add_item(CH_NL, 1, CH_NL);               // trailing space dropped
		add_item(CH_NL, 1, CH_NL);               // empty line
		// Kept trailing whitespace
		add_cfg(CFG_KEEP_TRAILING, 8'd1);
		add_item(CH_TAB, 0);
		add_item(CH_SPACE, 0);
		add_item(CH_NL, 3, CH_TAB, CH_SPACE, CH_NL);
		add_item(CH_NL, 1, CH_NL);               // kept newline with no gap
		// Widest pitch: tabs run into the column limit
		add_cfg(CFG_TAB_SIZE, 8'd31);
		add_item(CH_TAB, -1);
		add_item(CH_TAB, -1);
		add_item(CH_TAB, -1);
		add_item(CH_TAB, -1);
		add_item(CH_SPACE, -1);
		add_item(8'h78, -1);
		add_item(8'h79, -1);
		add_item(CH_NL, -1);
		// Pitch of zero falls back to 4
		add_cfg(CFG_TAB_SIZE, 8'd0);
		add_item(CH_TAB, 0);
		add_item(8'h7A, 2, CH_TAB, 8'h7A);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				drain_and_settle();
				write_reg(directed_rows[i].idx, directed_rows[i].val);
			end else begin
				send_item(directed_rows[i].val, directed_rows[i].n_typed,
					directed_rows[i].t0, directed_rows[i].t1, directed_rows[i].t2);
			end
		end

		// Random phases, each under its own configuration
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_and_settle();
			ts_val   = (ph_tab[p] < 0) ? $urandom_range(0, 31) : ph_tab[p];
			keep_val = (ph_keep[p] < 0) ? $urandom_range(0, 1) : ph_keep[p];
			write_reg(CFG_KEEP_TRAILING, keep_val);
			write_reg(CFG_TAB_SIZE, ts_val);
			no_gaps = (p == 4);
			if (p == 2)
				hold_req = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_item(text_byte(ph_nl[p]), -1, '0, '0, '0);
		end
		drain_and_settle();

		$display("Covered %0d items and %0d output bytes across %0d register writes,",
			items_in, bytes_out, cfg_writes);
		$display("pitches 0 to 31, trimmed and kept line ends, %0d column-limit events",
			limit_hits);
		if (errors == 0)
			$display("entab_whitespace_compressor test passed");
		else
			$display("entab_whitespace_compressor test failed");
		$finish;
	end

endmodule
